### rtl/core/adx_trend_signal_trader_macros.svh
// Assertion helpers for the ADX trader; clk and rst_n must be in scope.
`ifndef ADX_TREND_SIGNAL_TRADER_MACROS_SVH
`define ADX_TREND_SIGNAL_TRADER_MACROS_SVH

// Overlapping implication, checked out of reset.
`define ADX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Non-overlapping implication, consequent checked in the following cycle.
`define ADX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/adx_pkg.sv
// ----------------------------------------------------------------------------
// adx_pkg
// Shared types and fixed-point widths of the ADX trend trader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adx_pkg;

  localparam int PRICE_W = 32;
  localparam int FRAC_W  = 16;
  localparam int ATR_W   = PRICE_W + FRAC_W;
  localparam int DI_W    = FRAC_W + 1;
  localparam int ADX_W   = 23;
  localparam int POS_W   = 11;
  localparam int LIM_W   = 10;
  localparam int THR_W   = 7;
  localparam int ALPHA_W = 16;
  localparam int MONEY_W = 48;
  localparam int Q_W     = 23;
  localparam int CNT_W   = 5;
  localparam int PROD_W  = ATR_W + ALPHA_W;

  localparam logic [DI_W-1:0]  DI_CAP   = '1;
  localparam logic [CNT_W-1:0] DI_STEPS = CNT_W'(DI_W);
  localparam logic [CNT_W-1:0] DX_STEPS = CNT_W'(Q_W);

  localparam logic [MONEY_W:0] S48_MAX = {2'b00, {(MONEY_W-1){1'b1}}};
  localparam logic [MONEY_W:0] S48_MIN = {2'b11, {(MONEY_W-1){1'b0}}};

  // register byte addresses [3:2]
  localparam logic [1:0] REG_ALPHA = 2'd0;
  localparam logic [1:0] REG_THR   = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  localparam logic [15:0] ALPHA_RST = 16'd6242;
  localparam logic [6:0]  THR_RST   = 7'd25;
  localparam logic [9:0]  LIMIT_RST = 10'd5;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_BUY  = 2'd1,
    ACT_SELL = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_TR,
    OP_EMA_MUL,
    OP_EMA_UPD,
    OP_DI_START,
    OP_DI_TAKE,
    OP_DX_START,
    OP_DX_TAKE,
    OP_TRADE,
    OP_PNL_MUL,
    OP_FINISH
  } dp_op_t;

  typedef enum logic [1:0] {
    SEL_ATR,
    SEL_PDI,
    SEL_MDI,
    SEL_ADX
  } ema_sel_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_TR,
    S_ATR_MUL,
    S_ATR_UPD,
    S_PDIV_START,
    S_PDIV_WAIT,
    S_MDIV_START,
    S_MDIV_WAIT,
    S_PDI_MUL,
    S_PDI_UPD,
    S_MDI_MUL,
    S_MDI_UPD,
    S_DX_START,
    S_DX_WAIT,
    S_ADX_MUL,
    S_ADX_UPD,
    S_TRADE,
    S_PNL_MUL,
    S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t   op;
    ema_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic primed;
    logic div_busy;
    logic out_busy;
  } dp_stat_t;

endpackage

### rtl/core/adx_div.sv
// ----------------------------------------------------------------------------
// adx_div
// Restoring divider, one quotient bit per cycle, shared by DI and DX.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adx_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [adx_pkg::ATR_W-1:0]     rem_init,
  input  logic [adx_pkg::Q_W-1:0]       low_init,
  input  logic [adx_pkg::ATR_W-1:0]     divisor,
  input  logic [adx_pkg::CNT_W-1:0]     steps,
  output logic                          busy,
  output logic [adx_pkg::Q_W-1:0]       quot
);
  import adx_pkg::*;

  logic [ATR_W-1:0] rem_r, rem_nxt;
  logic [ATR_W-1:0] dvs_r;
  logic [Q_W-1:0]   sh_r, sh_nxt;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ATR_W:0]   trial;
  logic             ge;

  always_comb begin
    trial   = {rem_r, sh_r[Q_W-1]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? ATR_W'(trial - {1'b0, dvs_r}) : trial[ATR_W-1:0];
    sh_nxt  = {sh_r[Q_W-2:0], 1'b0};
    q_nxt   = {q_r[Q_W-2:0], ge};
    cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= steps;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      sh_r  <= low_init;
      dvs_r <= divisor;
      q_r   <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      sh_r  <= sh_nxt;
      q_r   <= q_nxt;
    end
  end

  assign busy = cnt_r != '0;
  assign quot = q_r;

endmodule

### rtl/core/adx_ctrl.sv
// ----------------------------------------------------------------------------
// adx_ctrl
// Sequencer: walks one bar through TR, ATR, DI, DX, ADX, trade and PnL; a priming bar goes straight to PnL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adx_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  adx_pkg::dp_stat_t  stat,
  output adx_pkg::dp_cmd_t   cmd
);
  import adx_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    cmd.sel   = SEL_ATR;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = stat.primed ? S_TR : S_PNL_MUL;
        end
      end
      S_TR: begin
        cmd.op    = OP_TR;
        state_nxt = S_ATR_MUL;
      end
      S_ATR_MUL: begin
        cmd.op    = OP_EMA_MUL;
        state_nxt = S_ATR_UPD;
      end
      S_ATR_UPD: begin
        cmd.op    = OP_EMA_UPD;
        state_nxt = S_PDIV_START;
      end
      S_PDIV_START: begin
        cmd.op    = OP_DI_START;
        cmd.sel   = SEL_PDI;
        state_nxt = S_PDIV_WAIT;
      end
      S_PDIV_WAIT: begin
        cmd.sel = SEL_PDI;
        if (!stat.div_busy) begin
          cmd.op    = OP_DI_TAKE;
          state_nxt = S_MDIV_START;
        end
      end
      S_MDIV_START: begin
        cmd.op    = OP_DI_START;
        cmd.sel   = SEL_MDI;
        state_nxt = S_MDIV_WAIT;
      end
      S_MDIV_WAIT: begin
        cmd.sel = SEL_MDI;
        if (!stat.div_busy) begin
          cmd.op    = OP_DI_TAKE;
          state_nxt = S_PDI_MUL;
        end
      end
      S_PDI_MUL: begin
        cmd.op    = OP_EMA_MUL;
        cmd.sel   = SEL_PDI;
        state_nxt = S_PDI_UPD;
      end
      S_PDI_UPD: begin
        cmd.op    = OP_EMA_UPD;
        cmd.sel   = SEL_PDI;
        state_nxt = S_MDI_MUL;
      end
      S_MDI_MUL: begin
        cmd.op    = OP_EMA_MUL;
        cmd.sel   = SEL_MDI;
        state_nxt = S_MDI_UPD;
      end
      S_MDI_UPD: begin
        cmd.op    = OP_EMA_UPD;
        cmd.sel   = SEL_MDI;
        state_nxt = S_DX_START;
      end
      S_DX_START: begin
        cmd.op    = OP_DX_START;
        state_nxt = S_DX_WAIT;
      end
      S_DX_WAIT: begin
        if (!stat.div_busy) begin
          cmd.op    = OP_DX_TAKE;
          state_nxt = S_ADX_MUL;
        end
      end
      S_ADX_MUL: begin
        cmd.op    = OP_EMA_MUL;
        cmd.sel   = SEL_ADX;
        state_nxt = S_ADX_UPD;
      end
      S_ADX_UPD: begin
        cmd.op    = OP_EMA_UPD;
        cmd.sel   = SEL_ADX;
        state_nxt = S_TRADE;
      end
      S_TRADE: begin
        cmd.op    = OP_TRADE;
        state_nxt = S_PNL_MUL;
      end
      S_PNL_MUL: begin
        cmd.op    = OP_PNL_MUL;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output word is free
        if (!stat.out_busy) begin
          cmd.op    = OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/adx_dp.sv
// ----------------------------------------------------------------------------
// adx_dp
// Datapath: bar registers, indicator state, EMA multiplier, divider, P&L.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adx_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  adx_pkg::dp_cmd_t                cmd,
  output adx_pkg::dp_stat_t               stat,
  input  logic [adx_pkg::ALPHA_W-1:0]     alpha,
  input  logic [adx_pkg::THR_W-1:0]       threshold,
  input  logic [adx_pkg::LIM_W-1:0]       limit,
  input  logic [adx_pkg::PRICE_W-1:0]     bar_high,
  input  logic [adx_pkg::PRICE_W-1:0]     bar_low,
  input  logic [adx_pkg::PRICE_W-1:0]     bar_close,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_trade_action,
  output logic signed [adx_pkg::POS_W-1:0] out_held_position,
  output logic signed [adx_pkg::MONEY_W-1:0] out_cash_total,
  output logic signed [adx_pkg::MONEY_W-1:0] out_marked_pnl,
  output logic [adx_pkg::ADX_W-1:0]       out_adx_value
);
  import adx_pkg::*;

  localparam int PNL_W = POS_W + PRICE_W + 1;

  // control state
  logic [1:0]                phase_r;
  logic signed [POS_W-1:0]   units_r;
  logic signed [MONEY_W-1:0] cash_r;
  logic [ATR_W-1:0]          atr_r;
  logic [DI_W-1:0]           pdi_r, mdi_r;
  logic [ADX_W-1:0]          adx_r;
  logic [PRICE_W-1:0]        ph_r, pl_r, pc_r;
  logic                      out_valid_r;

  // payload / scratch
  logic [PRICE_W-1:0]        h_r, l_r, c_r;
  logic [PRICE_W-1:0]        tr_r, dmp_r, dmn_r;
  logic [DI_W-1:0]           rp_r, rn_r;
  logic [ADX_W-1:0]          dx_r;
  logic [PROD_W-1:0]         prod_r;
  logic                      up_r;
  logic                      dz_r, ds_r;
  logic signed [PNL_W-1:0]   pmul_r;
  action_t                   act_r;
  logic [1:0]                o_act_r;
  logic signed [POS_W-1:0]   o_pos_r;
  logic signed [MONEY_W-1:0] o_cash_r, o_pnl_r;
  logic [ADX_W-1:0]          o_adx_r;

  // TR and directional movement
  logic [PRICE_W-1:0] hl, hc, lc, tr_a, tr_nxt;
  always_comb begin
    hl     = (h_r >= l_r) ? h_r - l_r : '0;
    hc     = (h_r >= pc_r) ? h_r - pc_r : pc_r - h_r;
    lc     = (l_r >= pc_r) ? l_r - pc_r : pc_r - l_r;
    tr_a   = (hl >= hc) ? hl : hc;
    tr_nxt = (tr_a >= lc) ? tr_a : lc;
  end

  // EMA operand select
  logic [ATR_W-1:0] ex, et, ediff, estep, enew;
  always_comb begin
    case (cmd.sel)
      SEL_ATR: begin
        ex = atr_r;
        et = {tr_r, {FRAC_W{1'b0}}};
      end
      SEL_PDI: begin
        ex = ATR_W'(pdi_r);
        et = ATR_W'(rp_r);
      end
      SEL_MDI: begin
        ex = ATR_W'(mdi_r);
        et = ATR_W'(rn_r);
      end
      SEL_ADX: begin
        ex = ATR_W'(adx_r);
        et = ATR_W'(dx_r);
      end
      default: begin
        ex = atr_r;
        et = atr_r;
      end
    endcase
    ediff = (et >= ex) ? et - ex : ex - et;
    estep = prod_r[PROD_W-1:ALPHA_W];
    if (phase_r == 2'd1) begin
      enew = et;
    end else begin
      enew = up_r ? ex + estep : ex - estep;
    end
  end

  // divider operands
  logic [DI_W:0]       di_sum;
  logic [DI_W-1:0]     di_diff;
  logic [Q_W:0]        dx_num;
  logic [PRICE_W-1:0]  dm_sel;
  logic [ATR_W-1:0]    dm_scaled;
  logic                div_start;
  logic [ATR_W-1:0]    div_rem, div_dvs;
  logic [Q_W-1:0]      div_low, div_q;
  logic [CNT_W-1:0]    div_steps;
  logic                div_busy;
  logic [DI_W-1:0]     di_raw;

  always_comb begin
    di_sum    = {1'b0, pdi_r} + {1'b0, mdi_r};
    di_diff   = (pdi_r >= mdi_r) ? pdi_r - mdi_r : mdi_r - pdi_r;
    dx_num    = (Q_W+1)'(di_diff) * (Q_W+1)'(100);
    dm_sel    = (cmd.sel == SEL_MDI) ? dmn_r : dmp_r;
    // dm * 2^32 / atr: quotient bits above DI_W only matter through saturation
    dm_scaled = ATR_W'({dm_sel, {(2*FRAC_W-DI_W){1'b0}}});
    div_start = (cmd.op == OP_DI_START) || (cmd.op == OP_DX_START);
    if (cmd.op == OP_DX_START) begin
      div_rem   = ATR_W'(dx_num[Q_W:Q_W-DI_W+1]);
      div_low   = {dx_num[Q_W-DI_W:0], {FRAC_W{1'b0}}};
      div_dvs   = ATR_W'(di_sum);
      div_steps = DX_STEPS;
    end else begin
      div_rem   = dm_scaled;
      div_low   = '0;
      div_dvs   = atr_r;
      div_steps = DI_STEPS;
    end
    di_raw = dz_r ? '0 : (ds_r ? DI_CAP : div_q[DI_W-1:0]);
  end

  adx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem),
    .low_init (div_low),
    .divisor  (div_dvs),
    .steps    (div_steps),
    .busy     (div_busy),
    .quot     (div_q)
  );

  // trade decision
  logic [ADX_W-1:0]          thr;
  logic signed [POS_W-1:0]   lim_s;
  logic                      buy, sell;
  logic signed [MONEY_W:0]   cash_buy, cash_sell, pnl_sum;
  logic signed [MONEY_W-1:0] cash_buy_s, cash_sell_s, pnl_s;

  function automatic logic signed [MONEY_W-1:0] sat48(input logic signed [MONEY_W:0] v);
    logic signed [MONEY_W-1:0] r;
    if (v > $signed(S48_MAX)) begin
      r = S48_MAX[MONEY_W-1:0];
    end else if (v < $signed(S48_MIN)) begin
      r = S48_MIN[MONEY_W-1:0];
    end else begin
      r = v[MONEY_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    thr   = {threshold, {FRAC_W{1'b0}}};
    lim_s = $signed({1'b0, limit});
    buy   = (di_sum != '0) && (units_r < lim_s) && (adx_r > thr);
    sell  = (di_sum != '0) && !buy && (units_r > -lim_s) && (adx_r < thr);
    cash_buy    = $signed({cash_r[MONEY_W-1], cash_r})
                - $signed({{(MONEY_W+1-PRICE_W){1'b0}}, c_r});
    cash_sell   = $signed({cash_r[MONEY_W-1], cash_r})
                + $signed({{(MONEY_W+1-PRICE_W){1'b0}}, c_r});
    cash_buy_s  = sat48(cash_buy);
    cash_sell_s = sat48(cash_sell);
    pnl_sum     = $signed({cash_r[MONEY_W-1], cash_r}) + (MONEY_W+1)'(pmul_r);
    pnl_s       = sat48(pnl_sum);
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 2'd0;
      units_r     <= '0;
      cash_r      <= '0;
      atr_r       <= '0;
      pdi_r       <= '0;
      mdi_r       <= '0;
      adx_r       <= '0;
      ph_r        <= '0;
      pl_r        <= '0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (cmd.op != OP_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_EMA_UPD: begin
          case (cmd.sel)
            SEL_ATR: atr_r <= enew;
            SEL_PDI: pdi_r <= enew[DI_W-1:0];
            SEL_MDI: mdi_r <= enew[DI_W-1:0];
            SEL_ADX: adx_r <= enew[ADX_W-1:0];
            default: atr_r <= atr_r;
          endcase
        end
        OP_TRADE: begin
          if (buy) begin
            units_r <= units_r + POS_W'(1);
            cash_r  <= cash_buy_s;
          end else if (sell) begin
            units_r <= units_r - POS_W'(1);
            cash_r  <= cash_sell_s;
          end
        end
        OP_FINISH: begin
          phase_r     <= (phase_r == 2'd0) ? 2'd1 : 2'd2;
          ph_r        <= h_r;
          pl_r        <= l_r;
          pc_r        <= c_r;
          out_valid_r <= 1'b1;
        end
        default: begin
          phase_r <= phase_r;
        end
      endcase
    end
  end

  // scratch and output registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        h_r   <= bar_high;
        l_r   <= bar_low;
        c_r   <= bar_close;
        act_r <= ACT_NONE;
      end
      OP_TR: begin
        tr_r  <= tr_nxt;
        dmp_r <= (h_r > ph_r) ? h_r - ph_r : '0;
        dmn_r <= (pl_r > l_r) ? pl_r - l_r : '0;
      end
      OP_EMA_MUL: begin
        prod_r <= PROD_W'(ediff) * PROD_W'(alpha);
        up_r   <= et >= ex;
      end
      OP_DI_START: begin
        dz_r <= atr_r == '0;
        ds_r <= dm_scaled >= atr_r;
      end
      OP_DI_TAKE: begin
        if (cmd.sel == SEL_MDI) begin
          rn_r <= di_raw;
        end else begin
          rp_r <= di_raw;
        end
      end
      OP_DX_START: begin
        dz_r <= di_sum == '0;
        ds_r <= 1'b0;
      end
      OP_DX_TAKE: begin
        dx_r <= dz_r ? '0 : div_q[ADX_W-1:0];
      end
      OP_TRADE: begin
        act_r <= buy ? ACT_BUY : (sell ? ACT_SELL : ACT_NONE);
      end
      OP_PNL_MUL: begin
        pmul_r <= PNL_W'(units_r) * PNL_W'($signed({1'b0, c_r}));
      end
      OP_FINISH: begin
        o_act_r  <= act_r;
        o_pos_r  <= units_r;
        o_cash_r <= cash_r;
        o_pnl_r  <= pnl_s;
        o_adx_r  <= adx_r;
      end
      default: begin
        up_r <= up_r;
      end
    endcase
  end

  assign stat.primed   = phase_r != 2'd0;
  assign stat.div_busy = div_busy;
  assign stat.out_busy = out_valid_r && !out_ready;

  assign out_valid         = out_valid_r;
  assign out_trade_action  = o_act_r;
  assign out_held_position = o_pos_r;
  assign out_cash_total    = o_cash_r;
  assign out_marked_pnl    = o_pnl_r;
  assign out_adx_value     = o_adx_r;

endmodule

### rtl/core/adx_trend_signal_trader.sv
// The first bar after reset only primes the state; later bars run every step. Either
// may wait for the output word to be taken. One bar in flight at a time.
// The shared restoring divider sets the pace: 17 + 17 + 23 steps per bar.
// Synchronous active-low reset clears indicators, position, cash and the
// configuration to its defaults; no clearing pass.
// ----------------------------------------------------------------------------
// adx_trend_signal_trader
// ADX trend-following trader: EMA-smoothed ATR, DI and ADX with one-unit trades.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "adx_trend_signal_trader_macros.svh"

module adx_trend_signal_trader (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [adx_pkg::PRICE_W-1:0]         in_bar_high,
  input  logic [adx_pkg::PRICE_W-1:0]         in_bar_low,
  input  logic [adx_pkg::PRICE_W-1:0]         in_bar_close,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_trade_action,
  output logic signed [adx_pkg::POS_W-1:0]    out_held_position,
  output logic signed [adx_pkg::MONEY_W-1:0]  out_cash_total,
  output logic signed [adx_pkg::MONEY_W-1:0]  out_marked_pnl,
  output logic [adx_pkg::ADX_W-1:0]           out_adx_value,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import adx_pkg::*;

  logic [ALPHA_W-1:0] alpha_r;
  logic [THR_W-1:0]   thr_r;
  logic [LIM_W-1:0]   limit_r;
  logic               wr_en;
  dp_cmd_t            cmd;
  dp_stat_t           stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RST;
      thr_r   <= THR_RST;
      limit_r <= LIMIT_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_ALPHA: alpha_r <= pwdata[ALPHA_W-1:0];
        REG_THR:   thr_r   <= pwdata[THR_W-1:0];
        REG_LIMIT: limit_r <= pwdata[LIM_W-1:0];
        default:   alpha_r <= alpha_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ALPHA: prdata = 32'(alpha_r);
      REG_THR:   prdata = 32'(thr_r);
      REG_LIMIT: prdata = 32'(limit_r);
      default:   prdata = '0;
    endcase
  end

  adx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  adx_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .alpha             (alpha_r),
    .threshold         (thr_r),
    .limit             (limit_r),
    .bar_high          (in_bar_high),
    .bar_low           (in_bar_low),
    .bar_close         (in_bar_close),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_trade_action  (out_trade_action),
    .out_held_position (out_held_position),
    .out_cash_total    (out_cash_total),
    .out_marked_pnl    (out_marked_pnl),
    .out_adx_value     (out_adx_value)
  );

  `ADX_ASSERT_NEXT(a_one_bar, in_valid && in_ready, !in_ready, "second bar taken while busy")
  `ADX_ASSERT_NOW(a_action_code, out_valid, out_trade_action != 2'd3, "bad trade action code")
  `ADX_ASSERT_NOW(a_adx_range, out_valid, out_adx_value <= 23'd6553600, "ADX above 100 percent")

endmodule

### tb/sv/adx_trend_signal_trader_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adx_trend_signal_trader_checker
// Watches the bar, result and register ports, predicts each result word from
// its own copy of the indicator state, and compares field by field.
// ----------------------------------------------------------------------------
module adx_trend_signal_trader_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [adx_pkg::PRICE_W-1:0]         in_bar_high,
  input  logic [adx_pkg::PRICE_W-1:0]         in_bar_low,
  input  logic [adx_pkg::PRICE_W-1:0]         in_bar_close,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [1:0]                          out_trade_action,
  input  logic signed [adx_pkg::POS_W-1:0]    out_held_position,
  input  logic signed [adx_pkg::MONEY_W-1:0]  out_cash_total,
  input  logic signed [adx_pkg::MONEY_W-1:0]  out_marked_pnl,
  input  logic [adx_pkg::ADX_W-1:0]           out_adx_value,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  input  logic                                pready,
  output int                                  n_pending,
  output int                                  n_errors,
  output int                                  n_trades
);
  import adx_pkg::*;

  localparam longint MONEY_HI = 64'sd140737488355327;
  localparam longint MONEY_LO = -64'sd140737488355328;

  typedef struct packed {
    logic [1:0]                action;
    logic signed [POS_W-1:0]   pos;
    logic signed [MONEY_W-1:0] cash;
    logic signed [MONEY_W-1:0] pnl;
    logic [ADX_W-1:0]          adx;
  } trade_word_t;

  trade_word_t expected_words[$];

  logic [ALPHA_W-1:0] alpha;
  logic [THR_W-1:0]   thr;
  logic [LIM_W-1:0]   lim;
  logic [1:0]         phase;
  logic [PRICE_W-1:0] prev_h, prev_l, prev_c;
  logic [ATR_W-1:0]   atr;
  logic [DI_W-1:0]    pdi, mdi;
  logic [ADX_W-1:0]   adx;
  longint             units, cash;

  function automatic logic [ATR_W-1:0] smooth(logic [ATR_W-1:0] x, logic [ATR_W-1:0] t);
    logic [79:0] p;
    if (t >= x) begin
      p = 80'(t - x) * 80'(alpha);
      return x + ATR_W'(p >> ALPHA_W);
    end
    p = 80'(x - t) * 80'(alpha);
    return x - ATR_W'(p >> ALPHA_W);
  endfunction

  // DM * 2^32 / ATR, capped at the DI range
  function automatic logic [DI_W-1:0] di_ratio(logic [63:0] dm, logic [ATR_W-1:0] d);
    logic [127:0] q;
    if (d == 0) return '0;
    q = {32'd0, dm, 32'd0} / 128'(d);
    if (q > 128'(DI_CAP)) return DI_CAP;
    return q[DI_W-1:0];
  endfunction

  function automatic longint clamp48(longint v);
    if (v > MONEY_HI) return MONEY_HI;
    if (v < MONEY_LO) return MONEY_LO;
    return v;
  endfunction

  task automatic predict_bar(logic [PRICE_W-1:0] h, logic [PRICE_W-1:0] l,
                             logic [PRICE_W-1:0] c);
    trade_word_t w;
    longint tr, t, pnl;
    logic [63:0] dmp, dmn, sum, diff, dx, thq;
    logic [DI_W-1:0] rp, rn;
    logic seed;
    w.action = ACT_NONE;
    if (phase != 0) begin
      seed = (phase == 1);
      tr = longint'(h) - longint'(l);
      t = longint'(h) - longint'(prev_c); if (t < 0) t = -t; if (t > tr) tr = t;
      t = longint'(l) - longint'(prev_c); if (t < 0) t = -t; if (t > tr) tr = t;
      dmp = h > prev_h ? 64'(h - prev_h) : 64'd0;
      dmn = prev_l > l ? 64'(prev_l - l) : 64'd0;
      if (seed) atr = ATR_W'(tr) << FRAC_W;
      else atr = smooth(atr, ATR_W'(tr) << FRAC_W);
      rp = di_ratio(dmp, atr);
      rn = di_ratio(dmn, atr);
      if (seed) begin
        pdi = rp;
        mdi = rn;
      end else begin
        pdi = DI_W'(smooth(ATR_W'(pdi), ATR_W'(rp)));
        mdi = DI_W'(smooth(ATR_W'(mdi), ATR_W'(rn)));
      end
      sum = 64'(pdi) + 64'(mdi);
      diff = pdi > mdi ? 64'(pdi - mdi) : 64'(mdi - pdi);
      dx = (sum != 0) ? ((diff * 100) << FRAC_W) / sum : 64'd0;
      if (seed) adx = ADX_W'(dx);
      else adx = ADX_W'(smooth(ATR_W'(adx), ATR_W'(dx)));
      phase = 2;
      thq = 64'(thr) << FRAC_W;
      if (sum != 0) begin
        if (units < longint'(lim) && 64'(adx) > thq) begin
          units++;
          cash = clamp48(cash - longint'(c));
          w.action = ACT_BUY;
        end else if (units > -longint'(lim) && 64'(adx) < thq) begin
          units--;
          cash = clamp48(cash + longint'(c));
          w.action = ACT_SELL;
        end
      end
    end else begin
      phase = 1;
    end
    prev_h = h;
    prev_l = l;
    prev_c = c;
    pnl = clamp48(cash + units * longint'(c));
    w.pos = POS_W'(units);
    w.cash = MONEY_W'(cash);
    w.pnl = MONEY_W'(pnl);
    w.adx = adx;
    expected_words = {expected_words, w};
  endtask

  always @(posedge clk) begin
    trade_word_t e;
    if (!rst_n) begin
      alpha = ALPHA_RST;
      thr = THR_RST;
      lim = LIMIT_RST;
      phase = 0;
      prev_h = '0;
      prev_l = '0;
      prev_c = '0;
      atr = '0;
      pdi = '0;
      mdi = '0;
      adx = '0;
      units = 0;
      cash = 0;
      expected_words.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_ALPHA: alpha = pwdata[ALPHA_W-1:0];
          REG_THR:   thr = pwdata[THR_W-1:0];
          REG_LIMIT: lim = pwdata[LIM_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          n_errors++;
          $display("%0t: result word with none expected, actual %h", $time,
                   {out_trade_action, out_held_position, out_cash_total,
                    out_marked_pnl, out_adx_value});
        end else begin
          e = expected_words.pop_front();
          if (out_trade_action != ACT_NONE) n_trades++;
          if (out_trade_action !== e.action) begin
            n_errors++;
            $display("%0t: action exp %0d got %0d", $time, e.action, out_trade_action);
          end
          if (out_held_position !== e.pos) begin
            n_errors++;
            $display("%0t: position exp %0d got %0d", $time, e.pos, out_held_position);
          end
          if (out_cash_total !== e.cash) begin
            n_errors++;
            $display("%0t: cash exp %0d got %0d", $time, e.cash, out_cash_total);
          end
          if (out_marked_pnl !== e.pnl) begin
            n_errors++;
            $display("%0t: pnl exp %0d got %0d", $time, e.pnl, out_marked_pnl);
          end
          if (out_adx_value !== e.adx) begin
            n_errors++;
            $display("%0t: adx exp %0d got %0d", $time, e.adx, out_adx_value);
          end
        end
      end
      if (in_valid && in_ready) predict_bar(in_bar_high, in_bar_low, in_bar_close);
    end
    n_pending = expected_words.size();
  end

  initial begin
    n_pending = 0;
    n_errors = 0;
    n_trades = 0;
  end

endmodule

### tb/sv/adx_trend_signal_trader_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adx_trend_signal_trader_test
// Drives bars and register writes into the ADX trader under several idle and
// stall mixes; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module adx_trend_signal_trader_test;
  import adx_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SEG_ITEMS   = 117;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PRICE_W-1:0] in_bar_high = '0, in_bar_low = '0, in_bar_close = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_trade_action;
  logic signed [POS_W-1:0] out_held_position;
  logic signed [MONEY_W-1:0] out_cash_total, out_marked_pnl;
  logic [ADX_W-1:0] out_adx_value;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  int n_pending, n_errors, n_trades;
  int gap_pct = 0, stall_pct = 0;
  int cycles = 0;
  int n_bars = 0;
  longint price = 100000;
  int drift = 0;

  always #2 clk = ~clk;

  adx_trend_signal_trader u_top (.*);

  adx_trend_signal_trader_checker u_checker (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("adx_trend_signal_trader verification failed");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  task automatic send_bar(logic [31:0] h, logic [31:0] l, logic [31:0] c);
    int gap;
    gap = ($urandom_range(99) < gap_pct) ? $urandom_range(8, 1) : 0;
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_bar_high <= h;
    in_bar_low <= l;
    in_bar_close <= c;
    #1;
    while (!in_ready) begin
      @(negedge clk);
      #1;
    end
    @(posedge clk);
    n_bars++;
  endtask

  task automatic drain;
    @(negedge clk) in_valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk) penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // mostly a trending random walk; some bars fully random
  task automatic random_bar;
    longint h, l, c, spread;
    if ($urandom_range(99) < 10) begin
      send_bar($urandom, $urandom, $urandom);
    end else begin
      if ($urandom_range(99) < 8) drift = int'($urandom_range(400)) - 200;
      price = price + drift + int'($urandom_range(200)) - 100;
      if (price < 1000) price = 1000;
      if (price > 64'd4000000000) price = 64'd4000000000;
      spread = $urandom_range(300);
      h = price + $urandom_range(spread);
      l = price - $urandom_range(spread);
      c = l + $urandom_range(32'(h - l));
      send_bar(32'(h), 32'(l), 32'(c));
    end
  endtask

  initial begin
    int a_tab[8], t_tab[8], l_tab[8];
    a_tab = '{6242, 65535, 1, 0, 20000, 3000, 65535, 6242};
    t_tab = '{25, 0, 100, 50, 10, 40, 100, 25};
    l_tab = '{5, 1023, 0, 3, 1023, 2, 1023, 5};
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // priming, zero range, extremes, inverted bar, steady trends
    send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_bar(32'd0, 32'd0, 32'd0);
    send_bar(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_bar(32'd10, 32'd100, 32'd50);
    send_bar(32'd0, 32'hFFFF_FFFF, 32'd0);
    for (int i = 0; i < 9; i++)
      send_bar(32'(1000 + 60 * i), 32'(950 + 60 * i), 32'(990 + 60 * i));
    for (int i = 0; i < 9; i++)
      send_bar(32'(1500 - 60 * i), 32'(1450 - 60 * i), 32'(1460 - 60 * i));

    for (int s = 0; s < 8; s++) begin
      if (s > 0) begin
        drain();
        reg_write(REG_ALPHA, 32'(a_tab[s]));
        reg_write(REG_THR, 32'(t_tab[s]));
        reg_write(REG_LIMIT, 32'(l_tab[s]));
      end
      case (s % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 62; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 62; end
        default: begin gap_pct = 29; stall_pct = 29; end
      endcase
      for (int i = 0; i < SEG_ITEMS; i++) random_bar();
    end

    @(negedge clk) in_valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("Ran %0d bars over 8 register settings and 4 idle/stall mixes; %0d trades.",
             n_bars, n_trades);
    if (n_errors == 0) begin
      $display("adx_trend_signal_trader verification clean");
    end else begin
      $display("adx_trend_signal_trader verification failed");
    end
    $finish;
  end

endmodule
